### rtl/rsi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_pkg
// Shared constants for the ray / unit sphere intersection pipeline.
// ----------------------------------------------------------------------------
package rsi_pkg;

  // default fraction bits of the Q format
  localparam int FRAC_BITS_DEF = 16;

  // quotient bits kept by the root dividers (larger quotients saturate)
  localparam int QUO_W = 33;

  // configuration registers
  localparam int NUM_REGS = 6;
  localparam int CFG_IDX_W = 3;
  localparam logic [63:0] CFG_RESET [NUM_REGS] = '{
    64'h0000_0001_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0001_0000_0000
  };

  // result status codes
  localparam logic [1:0] ST_HIT   = 2'd0;
  localparam logic [1:0] ST_MISS  = 2'd1;
  localparam logic [1:0] ST_DEGEN = 2'd2;

endpackage

### rtl/ray_sphere_intersection.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_sphere_intersection
// Maps a fixed point ray through a 3x4 inverse affine transform and solves
// the quadratic against the unit sphere, giving near and far roots.
// ----------------------------------------------------------------------------
//  channel | direction | beat contents
//  in_     | slave     | tdata: origin_x,y,z, dir_x,y,z (32 bits each, low first)
//  out_    | master    | tdata: t_near, t_far; tuser: status
//  cfg_    | slave     | cfg_index selects register, cfg_data is the 64-bit value
//
//  One ray per cycle while the output is not stalled; most of the pipeline is
//  the one-bit-per-stage square root and the 33 stage root dividers.
//  Synchronous active-low reset clears valid bits and loads the transform
//  with its reset values. A stall at the output freezes the whole pipeline;
//  in_tready follows out_tready whenever the output register is full.
// ----------------------------------------------------------------------------
module ray_sphere_intersection
  import rsi_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // ray input
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [191:0]         in_tdata,   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
  // result output
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [63:0]          out_tdata,  // t_near, t_far
  output logic [1:0]           out_tuser,  // status
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  localparam int F    = FRAC_BITS;
  localparam int AW   = 64 - F;
  localparam int HW   = 65 - F;
  localparam int HIW  = AW - 32;
  localparam int DW   = 130 - 2 * F;
  localparam int SW   = 65 - F;
  localparam int NUMW = 67 - F;
  localparam int NW   = 66 - F;
  localparam int QW   = QUO_W;
  localparam int CW   = ((NW + F > AW + QW) ? NW + F : AW + QW) + 1;
  localparam int SB1W = 2 + HW + AW;
  localparam int SB2W = 4;

  // saturate a wide signed value to 32 bits
  function automatic logic [31:0] sat32(input logic signed [65:0] v);
    logic [31:0] r;
    r = v[31:0];
    if (v > 66'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -66'sd2147483648) begin
      r = 32'h8000_0000;
    end
    return r;
  endfunction

  // sign, rounding and saturation of a root quotient
  function automatic logic [31:0] root_fix(input logic [QW-1:0] q, input logic rnz,
                                           input logic neg, input logic sat);
    logic [QW:0]  qc;
    logic [QW:0]  nq;
    logic [31:0]  r;
    qc = (QW+1)'(q) + (QW+1)'(rnz);
    nq = (QW+1)'(0) - qc;
    if (!neg) begin
      if (sat || q > QW'(32'h7FFF_FFFF)) begin
        r = 32'h7FFF_FFFF;
      end else begin
        r = q[31:0];
      end
    end else begin
      if (sat || qc > (QW+1)'(32'h8000_0000)) begin
        r = 32'h8000_0000;
      end else begin
        r = nq[31:0];
      end
    end
    return r;
  endfunction

  logic en;
  logic out_tvalid_r;

  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en && rst_n;
  assign cfg_ready = rst_n;

  // configuration registers
  logic [63:0] cfg_r [NUM_REGS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        cfg_r[i] <= CFG_RESET[i];
      end
    end else if (cfg_valid && (32'(cfg_index) < NUM_REGS)) begin
      cfg_r[cfg_index] <= cfg_data;
    end
  end

  logic signed [31:0] row [3][3];
  logic signed [31:0] tr  [3];
  logic signed [31:0] org [3];
  logic signed [31:0] dir [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      row[r][0] = cfg_r[2*r][63:32];
      row[r][1] = cfg_r[2*r][31:0];
      row[r][2] = cfg_r[2*r+1][63:32];
      tr[r]     = cfg_r[2*r+1][31:0];
      org[r]    = in_tdata[32*r +: 32];
      dir[r]    = in_tdata[96 + 32*r +: 32];
    end
  end

  // stage 1: transform products
  logic               v1_r;
  logic signed [63:0] po_r [3][3];
  logic signed [63:0] pd_r [3][3];

  // stage 2: transform sums
  logic               v2_r;
  logic signed [64:0] so_r [3];
  logic signed [64:0] sd_r [3];

  // stage 3: sphere-space ray, saturated
  logic               v3_r;
  logic signed [31:0] mo_r [3];
  logic signed [31:0] md_r [3];
  logic signed [65:0] mo_w [3];

  // stage 4: dot product terms
  logic               v4_r;
  logic signed [63:0] pa_r [3];
  logic signed [63:0] ph_r [3];
  logic signed [63:0] pc_r [3];

  // stage 5: quadratic coefficients
  logic               v5_r;
  logic [AW-1:0]      a5_r;
  logic [HW-1:0]      h5_r;
  logic [HW-1:0]      c5_r;
  logic signed [64:0] sa_w;
  logic signed [64:0] sh_w;
  logic signed [64:0] sc_w;

  // stage 6: partial products of h*h and a*|c|
  logic               v6_r;
  logic [AW-1:0]      a6_r;
  logic [HW-1:0]      h6_r;
  logic               deg6_r;
  logic               cneg6_r;
  logic [63:0]        hp00_r;
  logic [HIW+31:0]    hp01_r;
  logic [2*HIW-1:0]   hp11_r;
  logic [63:0]        ap00_r;
  logic [HIW+31:0]    ap01_r;
  logic [HIW+31:0]    ap10_r;
  logic [2*HIW-1:0]   ap11_r;
  logic [AW-1:0]      ha_w;
  logic [AW-1:0]      ca_w;

  // stage 7: assembled products
  logic               v7_r;
  logic [AW-1:0]      a7_r;
  logic [HW-1:0]      h7_r;
  logic               deg7_r;
  logic               cneg7_r;
  logic [DW-1:0]      hh7_r;
  logic [DW-1:0]      ac7_r;

  // stage 8: discriminant and status
  logic               v8_r;
  logic [DW-1:0]      disc8_r;
  logic [1:0]         st8_r;
  logic [AW-1:0]      a8_r;
  logic [HW-1:0]      h8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
      v8_r <= v7_r;
    end
  end

  // stage 3, 5 and 6 combinational terms
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mo_w[i] = 66'(so_r[i] >>> F) + 66'(tr[i]);
    end
    sa_w = 65'(pa_r[0]) + 65'(pa_r[1]) + 65'(pa_r[2]);
    sh_w = 65'(ph_r[0]) + 65'(ph_r[1]) + 65'(ph_r[2]);
    sc_w = 65'(pc_r[0]) + 65'(pc_r[1]) + 65'(pc_r[2]);
    ha_w = h5_r[HW-1] ? AW'(-h5_r) : AW'(h5_r);
    ca_w = c5_r[HW-1] ? AW'(-c5_r) : AW'(c5_r);
  end

  // front pipeline data
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int j = 0; j < 3; j++) begin
          po_r[r][j] <= row[r][j] * org[j];
          pd_r[r][j] <= row[r][j] * dir[j];
        end
        so_r[r] <= 65'(po_r[r][0]) + 65'(po_r[r][1]) + 65'(po_r[r][2]);
        sd_r[r] <= 65'(pd_r[r][0]) + 65'(pd_r[r][1]) + 65'(pd_r[r][2]);
        mo_r[r] <= sat32(mo_w[r]);
        md_r[r] <= sat32(66'(sd_r[r] >>> F));
        pa_r[r] <= md_r[r] * md_r[r];
        ph_r[r] <= md_r[r] * mo_r[r];
        pc_r[r] <= mo_r[r] * mo_r[r];
      end
      a5_r <= sa_w[63:F];
      h5_r <= sh_w[64:F];
      c5_r <= sc_w[64:F] - (HW'(1) << F);

      a6_r    <= a5_r;
      h6_r    <= h5_r;
      deg6_r  <= (a5_r == '0);
      cneg6_r <= c5_r[HW-1];
      hp00_r  <= ha_w[31:0] * ha_w[31:0];
      hp01_r  <= (HIW+32)'(ha_w[31:0]) * (HIW+32)'(ha_w[AW-1:32]);
      hp11_r  <= (2*HIW)'(ha_w[AW-1:32]) * (2*HIW)'(ha_w[AW-1:32]);
      ap00_r  <= a5_r[31:0] * ca_w[31:0];
      ap01_r  <= (HIW+32)'(a5_r[31:0]) * (HIW+32)'(ca_w[AW-1:32]);
      ap10_r  <= (HIW+32)'(a5_r[AW-1:32]) * (HIW+32)'(ca_w[31:0]);
      ap11_r  <= (2*HIW)'(a5_r[AW-1:32]) * (2*HIW)'(ca_w[AW-1:32]);

      a7_r    <= a6_r;
      h7_r    <= h6_r;
      deg7_r  <= deg6_r;
      cneg7_r <= cneg6_r;
      hh7_r   <= DW'(hp00_r) + (DW'(hp01_r) << 33) + (DW'(hp11_r) << 64);
      ac7_r   <= DW'(ap00_r) + ((DW'(ap01_r) + DW'(ap10_r)) << 32) + (DW'(ap11_r) << 64);

      a8_r    <= a7_r;
      h8_r    <= h7_r;
      disc8_r <= cneg7_r ? hh7_r + ac7_r : hh7_r - ac7_r;
      if (deg7_r) begin
        st8_r <= ST_DEGEN;
      end else if (!cneg7_r && (ac7_r > hh7_r)) begin
        st8_r <= ST_MISS;
      end else begin
        st8_r <= ST_HIT;
      end
    end
  end

  // square root of the discriminant
  logic              sq_valid;
  logic [SW-1:0]     sq_root;
  logic [SB1W-1:0]   sq_sb;
  logic [1:0]        sq_st;
  logic signed [HW-1:0] sq_h;
  logic [AW-1:0]     sq_a;

  rsi_sqrt #(
    .DW  (DW),
    .SW  (SW),
    .SBW (SB1W)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v8_r),
    .in_rad    (disc8_r),
    .in_sb     ({st8_r, h8_r, a8_r}),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_sb    (sq_sb)
  );

  assign {sq_st, sq_h, sq_a} = sq_sb;

  // stage 9: root numerators
  logic              v9_r;
  logic [NUMW-1:0]   nn9_r;
  logic [NUMW-1:0]   nf9_r;
  logic [1:0]        st9_r;
  logic [AW-1:0]     a9_r;
  logic [NUMW-1:0]   nh_w;

  assign nh_w = NUMW'(0) - NUMW'(sq_h);

  // stage 10: magnitudes, signs and early saturation
  logic              v10_r;
  logic [NW-1:0]     mn10_r;
  logic [NW-1:0]     mf10_r;
  logic              negn10_r;
  logic              negf10_r;
  logic              satn10_r;
  logic              satf10_r;
  logic [1:0]        st10_r;
  logic [AW-1:0]     a10_r;
  logic [NW-1:0]     mn_w;
  logic [NW-1:0]     mf_w;
  logic [CW-1:0]     dlim_w;

  always_comb begin
    mn_w   = nn9_r[NUMW-1] ? NW'(-nn9_r) : NW'(nn9_r);
    mf_w   = nf9_r[NUMW-1] ? NW'(-nf9_r) : NW'(nf9_r);
    dlim_w = CW'(a9_r) << QW;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v9_r  <= 1'b0;
      v10_r <= 1'b0;
    end else if (en) begin
      v9_r  <= sq_valid;
      v10_r <= v9_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nn9_r    <= nh_w - NUMW'(sq_root);
      nf9_r    <= nh_w + NUMW'(sq_root);
      st9_r    <= sq_st;
      a9_r     <= sq_a;
      mn10_r   <= mn_w;
      mf10_r   <= mf_w;
      negn10_r <= nn9_r[NUMW-1];
      negf10_r <= nf9_r[NUMW-1];
      satn10_r <= (CW'(mn_w) << F) >= dlim_w;
      satf10_r <= (CW'(mf_w) << F) >= dlim_w;
      st10_r   <= st9_r;
      a10_r    <= a9_r;
    end
  end

  // root dividers
  logic            dn_valid;
  logic            df_valid;
  logic [QW-1:0]   dn_q;
  logic [QW-1:0]   df_q;
  logic            dn_rnz;
  logic            df_rnz;
  logic [SB2W-1:0] dn_sb;
  logic [1:0]      df_sb;

  rsi_div #(
    .NW  (NW),
    .AW  (AW),
    .FB  (F),
    .QW  (QW),
    .SBW (SB2W)
  ) u_div_near (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (v10_r),
    .in_mag     (mn10_r),
    .in_den     (a10_r),
    .in_sb      ({st10_r, negn10_r, satn10_r}),
    .out_valid  (dn_valid),
    .out_q      (dn_q),
    .out_rem_nz (dn_rnz),
    .out_sb     (dn_sb)
  );

  rsi_div #(
    .NW  (NW),
    .AW  (AW),
    .FB  (F),
    .QW  (QW),
    .SBW (2)
  ) u_div_far (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (v10_r),
    .in_mag     (mf10_r),
    .in_den     (a10_r),
    .in_sb      ({negf10_r, satf10_r}),
    .out_valid  (df_valid),
    .out_q      (df_q),
    .out_rem_nz (df_rnz),
    .out_sb     (df_sb)
  );

  // output register
  logic [1:0]  st_out_r;
  logic [31:0] tn_out_r;
  logic [31:0] tf_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= dn_valid & df_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_out_r <= dn_sb[3:2];
      if (dn_sb[3:2] == ST_HIT) begin
        tn_out_r <= root_fix(dn_q, dn_rnz, dn_sb[1], dn_sb[0]);
        tf_out_r <= root_fix(df_q, df_rnz, df_sb[1], df_sb[0]);
      end else begin
        tn_out_r <= '0;
        tf_out_r <= '0;
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = st_out_r;
  assign out_tdata  = {tf_out_r, tn_out_r};

endmodule

### rtl/rsi_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_sqrt
// Pipelined integer square root, rounded down, one result bit per stage.
// ----------------------------------------------------------------------------
module rsi_sqrt
  import rsi_pkg::*;
#(
  parameter int DW  = 130 - 2 * FRAC_BITS_DEF,
  parameter int SW  = 65 - FRAC_BITS_DEF,
  parameter int SBW = 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  logic [DW-1:0]  in_rad,
  input  logic [SBW-1:0] in_sb,
  output logic           out_valid,
  output logic [SW-1:0]  out_root,
  output logic [SBW-1:0] out_sb
);

  logic [DW-1:0]  rem_r    [SW];
  logic [SW-1:0]  root_r   [SW];
  logic [SBW-1:0] sb_r     [SW];
  logic [SW-1:0]  vld_r;
  logic [DW-1:0]  rem_nxt  [SW];
  logic [SW-1:0]  root_nxt [SW];
  logic [DW-1:0]  rin;
  logic [DW-1:0]  trial;
  logic [SW-1:0]  qin;

  // one trial subtract per stage, most significant root bit first
  always_comb begin
    for (int k = 0; k < SW; k++) begin
      if (k == 0) begin
        rin = in_rad;
        qin = '0;
      end else begin
        rin = rem_r[k-1];
        qin = root_r[k-1];
      end
      trial = (DW'(qin) << (SW - k)) | (DW'(1) << (2 * (SW - 1 - k)));
      rem_nxt[k]  = rin;
      root_nxt[k] = qin;
      if (rin >= trial) begin
        rem_nxt[k]  = rin - trial;
        root_nxt[k] = qin | (SW'(1) << (SW - 1 - k));
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[SW-2:0], in_valid};
    end
  end

  // stage data
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < SW; k++) begin
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
      end
      sb_r[0] <= in_sb;
      for (int k = 1; k < SW; k++) begin
        sb_r[k] <= sb_r[k-1];
      end
    end
  end

  assign out_valid = vld_r[SW-1];
  assign out_root  = root_r[SW-1];
  assign out_sb    = sb_r[SW-1];

endmodule

### rtl/rsi_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_div
// Pipelined restoring divider: floor(mag * 2^FB / den), one quotient bit
// per stage, with a flag for a nonzero remainder.
// ----------------------------------------------------------------------------
module rsi_div
  import rsi_pkg::*;
#(
  parameter int NW  = 66 - FRAC_BITS_DEF,
  parameter int AW  = 64 - FRAC_BITS_DEF,
  parameter int FB  = FRAC_BITS_DEF,
  parameter int QW  = QUO_W,
  parameter int SBW = 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  logic [NW-1:0]  in_mag,
  input  logic [AW-1:0]  in_den,
  input  logic [SBW-1:0] in_sb,
  output logic           out_valid,
  output logic [QW-1:0]  out_q,
  output logic           out_rem_nz,
  output logic [SBW-1:0] out_sb
);

  localparam int CW = ((NW + FB > AW + QW) ? NW + FB : AW + QW) + 1;

  logic [CW-1:0]  rem_r   [QW];
  logic [QW-1:0]  q_r     [QW];
  logic [AW-1:0]  den_r   [QW];
  logic [SBW-1:0] sb_r    [QW];
  logic [QW-1:0]  vld_r;
  logic [CW-1:0]  rem_nxt [QW];
  logic [QW-1:0]  q_nxt   [QW];
  logic [CW-1:0]  rin;
  logic [CW-1:0]  dsh;
  logic [QW-1:0]  qin;
  logic [AW-1:0]  din;

  // compare and subtract the shifted divisor, top quotient bit first
  always_comb begin
    for (int k = 0; k < QW; k++) begin
      if (k == 0) begin
        rin = CW'(in_mag) << FB;
        qin = '0;
        din = in_den;
      end else begin
        rin = rem_r[k-1];
        qin = q_r[k-1];
        din = den_r[k-1];
      end
      dsh = CW'(din) << (QW - 1 - k);
      rem_nxt[k] = rin;
      q_nxt[k]   = qin;
      if (rin >= dsh) begin
        rem_nxt[k] = rin - dsh;
        q_nxt[k]   = qin | (QW'(1) << (QW - 1 - k));
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[QW-2:0], in_valid};
    end
  end

  // stage data
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QW; k++) begin
        rem_r[k] <= rem_nxt[k];
        q_r[k]   <= q_nxt[k];
      end
      den_r[0] <= in_den;
      sb_r[0]  <= in_sb;
      for (int k = 1; k < QW; k++) begin
        den_r[k] <= den_r[k-1];
        sb_r[k]  <= sb_r[k-1];
      end
    end
  end

  assign out_valid  = vld_r[QW-1];
  assign out_q      = q_r[QW-1];
  assign out_rem_nz = |rem_r[QW-1];
  assign out_sb     = sb_r[QW-1];

endmodule
